// ===== rtl/crs_pkg.sv =====
// Shared types, sizes and action codes for the clip rectangle stack.
// Used by every module of the block but crs_ram; depends on nothing.
package crs_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CRD_W       = 15;
	localparam int RECT_W      = 4 * CRD_W;
	localparam int WIDE_W      = 19;
	localparam int OUT_W       = 18;
	localparam int IN_TDATA_W  = 64;
	localparam int IN_TUSER_W  = 4;
	localparam int OUT_TDATA_W = 80;
	localparam int CFG_IDX_W   = 2;

	localparam logic [3:0] ACT_PUSH    = 4'd0;
	localparam logic [3:0] ACT_POP     = 4'd1;
	localparam logic [3:0] ACT_RESET   = 4'd2;
	localparam logic [3:0] ACT_POINT   = 4'd3;
	localparam logic [3:0] ACT_VISIBLE = 4'd4;
	localparam logic [3:0] ACT_HSPAN   = 4'd5;
	localparam logic [3:0] ACT_VSPAN   = 4'd6;
	localparam logic [3:0] ACT_CLIP    = 4'd7;
	localparam logic [3:0] ACT_READ    = 4'd8;

	localparam logic [CFG_IDX_W-1:0] REG_SURF_W = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SURF_H = 2'd1;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef struct packed {
		logic [CRD_W-1:0] h;
		logic [CRD_W-1:0] w;
		logic [CRD_W-1:0] y;
		logic [CRD_W-1:0] x;
	} rect_t;

	typedef struct packed {
		logic in_load;
		logic commit;
		logic ram_rd;
		logic pop_commit;
	} crs_cmd_t;

	typedef struct packed {
		logic need_read;
	} crs_stat_t;

	function automatic wide_t smax(input wide_t a, input wide_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic wide_t smin(input wide_t a, input wide_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic wide_t clamp0(input wide_t a);
		return (a < 0) ? '0 : a;
	endfunction

endpackage

// ===== rtl/crs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the rectangle stack; depends on nothing.
module crs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/crs_ctrl.sv =====
// Sequencing state machine of the clip rectangle stack.
// Depends on crs_pkg; drives the datapath through crs_cmd_t.
module crs_ctrl
	import crs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  crs_stat_t stat,
	output crs_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_POPRD = 2'd2;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.in_load = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.need_read) begin
					cmd.ram_rd = 1'b1;
					state_d    = ST_POPRD;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_POPRD: begin
				if (out_free) begin
					cmd.pop_commit = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit || cmd.pop_commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/crs_dpath.sv =====
// Datapath of the clip rectangle stack: input and result registers, surface
// registers, active rectangle, depth counter and the stack RAM. Uses crs_pkg.
module crs_dpath
	import crs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CRD_W-1:0]       cfg_data,
	input  crs_cmd_t               cmd,
	output crs_stat_t              stat
);

	logic [3:0]       act_q;
	logic [15:0]      x_q, y_q, w_q, h_q;
	logic [CRD_W-1:0] surf_w_q, surf_h_q;
	rect_t            active_q;
	cnt_t             count_q;
	rect_t            rd_rect;
	rect_t            push_rect;
	logic             depth0, full, ram_we;

	wide_t ax, ay, aw, ah, ax2, ay2, sw, sh;
	wide_t x, y, w, h, xw, yh;
	wide_t mx, my, cw, ch, nx2, ny2;
	wide_t px0, py0, pw0, ph0, qx, qy, qw, qh, qw1, qh1, rw, rh;
	wide_t ex, ey;
	wide_t sx1, sw2, sy1, sh2;
	wide_t res_x, res_y, res_w, res_h;
	logic  res_pass;
	cnt_t  res_cnt;

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			act_q <= s_tuser;
			x_q   <= s_tdata[15:0];
			y_q   <= s_tdata[31:16];
			w_q   <= s_tdata[47:32];
			h_q   <= s_tdata[63:48];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surf_w_q <= CRD_W'(640);
			surf_h_q <= CRD_W'(480);
		end else if (cfg_valid) begin
			if (cfg_index == REG_SURF_W) begin
				surf_w_q <= cfg_data;
			end else if (cfg_index == REG_SURF_H) begin
				surf_h_q <= cfg_data;
			end
		end
	end

	assign depth0 = (count_q == '0);
	assign full   = (count_q == CNT_W'(STACK_DEPTH));
	assign stat.need_read = (act_q == ACT_POP) && (count_q > CNT_W'(1));

	assign sw  = {4'b0, surf_w_q};
	assign sh  = {4'b0, surf_h_q};
	assign ax  = depth0 ? '0 : {4'b0, active_q.x};
	assign ay  = depth0 ? '0 : {4'b0, active_q.y};
	assign aw  = depth0 ? sw : {4'b0, active_q.w};
	assign ah  = depth0 ? sh : {4'b0, active_q.h};
	assign ax2 = ax + aw;
	assign ay2 = ay + ah;

	assign x  = {{3{x_q[15]}}, x_q};
	assign y  = {{3{y_q[15]}}, y_q};
	assign w  = {{3{w_q[15]}}, w_q};
	assign h  = {{3{h_q[15]}}, h_q};
	assign xw = x + w;
	assign yh = y + h;

	// intersection with the active rectangle, shared by push and rect clip
	assign mx  = smax(x, ax);
	assign my  = smax(y, ay);
	assign nx2 = smin(xw, ax2);
	assign ny2 = smin(yh, ay2);
	assign cw  = nx2 - mx;
	assign ch  = ny2 - my;

	// push: intersect unless empty, then clamp to the surface
	assign px0 = depth0 ? x : mx;
	assign py0 = depth0 ? y : my;
	assign pw0 = depth0 ? w : clamp0(cw);
	assign ph0 = depth0 ? h : clamp0(ch);
	assign qx  = (px0 < 0) ? '0 : px0;
	assign qy  = (py0 < 0) ? '0 : py0;
	// a negative corner only occurs at depth 0, where corner plus size is x+w
	assign qw1 = (px0 < 0) ? clamp0(xw) : pw0;
	assign qh1 = (py0 < 0) ? clamp0(yh) : ph0;
	assign qw  = qw1;
	assign qh  = qh1;
	// far edge of the clamped rectangle, taken without another adder
	assign ex  = (px0 < 0) ? qw1 : (depth0 ? xw : smax(nx2, mx));
	assign ey  = (py0 < 0) ? qh1 : (depth0 ? yh : smax(ny2, my));
	assign rw  = clamp0((ex > sw) ? sw - qx : qw);
	assign rh  = clamp0((ey > sh) ? sh - qy : qh);
	assign push_rect = '{h: rh[CRD_W-1:0], w: rw[CRD_W-1:0],
		y: qy[CRD_W-1:0], x: qx[CRD_W-1:0]};

	// span clips: the clipped end is still x+w (or y+h)
	assign sx1 = (x < ax) ? ax : x;
	assign sw2 = (xw > ax2) ? ax2 - sx1 : ((x < ax) ? xw - ax : w);
	assign sy1 = (y < ay) ? ay : y;
	assign sh2 = (yh > ay2) ? ay2 - sy1 : ((y < ay) ? yh - ay : h);

	always_comb begin
		res_x    = ax;
		res_y    = ay;
		res_w    = aw;
		res_h    = ah;
		res_pass = 1'b0;
		res_cnt  = count_q;
		ram_we   = 1'b0;
		case (act_q)
			ACT_PUSH: begin
				if (!full) begin
					ram_we   = cmd.commit;
					res_cnt  = count_q + CNT_W'(1);
					res_pass = 1'b1;
					res_x    = qx;
					res_y    = qy;
					res_w    = rw;
					res_h    = rh;
				end
			end
			ACT_POP: begin
				if (!depth0) begin
					res_cnt  = '0;
					res_pass = 1'b1;
					res_x    = '0;
					res_y    = '0;
					res_w    = sw;
					res_h    = sh;
				end
			end
			ACT_RESET: begin
				res_cnt  = '0;
				res_pass = 1'b1;
				res_x    = '0;
				res_y    = '0;
				res_w    = sw;
				res_h    = sh;
			end
			ACT_POINT: begin
				res_x    = x;
				res_y    = y;
				res_w    = '0;
				res_h    = '0;
				res_pass = (x >= ax) && (x < ax2) && (y >= ay) && (y < ay2);
			end
			ACT_VISIBLE: begin
				res_x    = x;
				res_y    = y;
				res_w    = w;
				res_h    = h;
				res_pass = (aw > 0) && (ah > 0) && (w > 0) && (h > 0) &&
					(x < ax2) && (xw > ax) && (y < ay2) && (yh > ay);
			end
			ACT_HSPAN: begin
				res_x = x;
				res_y = y;
				res_w = w;
				res_h = '0;
				if ((w > 0) && (y >= ay) && (y < ay2)) begin
					res_x    = sx1;
					res_w    = sw2;
					res_pass = (sw2 > 0);
				end
			end
			ACT_VSPAN: begin
				res_x = x;
				res_y = y;
				res_w = '0;
				res_h = h;
				if ((h > 0) && (x >= ax) && (x < ax2)) begin
					res_y    = sy1;
					res_h    = sh2;
					res_pass = (sh2 > 0);
				end
			end
			ACT_CLIP: begin
				res_x = x;
				res_y = y;
				res_w = w;
				res_h = h;
				if ((w > 0) && (h > 0)) begin
					res_x    = mx;
					res_y    = my;
					res_w    = cw;
					res_h    = ch;
					res_pass = (cw > 0) && (ch > 0);
				end
			end
			ACT_READ: begin
				res_pass = (aw > 0) && (ah > 0);
			end
			default: begin
				res_pass = 1'b0;
			end
		endcase
	end

	crs_ram #(
		.WIDTH(RECT_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ADDR_W'(count_q)),
		.wdata(push_rect),
		.re   (cmd.ram_rd),
		.raddr(ADDR_W'(count_q - CNT_W'(1)) - ADDR_W'(1)),
		.rdata(rd_rect)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= res_cnt;
		end else if (cmd.pop_commit) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			active_q <= push_rect;
		end else if (cmd.pop_commit) begin
			active_q <= rd_rect;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_tdata <= {2'b0, 5'(res_cnt), res_pass, res_h[OUT_W-1:0],
				res_w[OUT_W-1:0], res_y[OUT_W-1:0], res_x[OUT_W-1:0]};
		end else if (cmd.pop_commit) begin
			m_tdata <= {2'b0, 5'(count_q - CNT_W'(1)), 1'b1,
				3'b0, rd_rect.h, 3'b0, rd_rect.w, 3'b0, rd_rect.y, 3'b0, rd_rect.x};
		end
	end

endmodule

// ===== rtl/clip_rectangle_stack_unit.sv =====
// Clip rectangle stack: the result is registered in the execute state after the
// input transfer, or after one stack RAM read for a pop that uncovers a stacked
// rectangle. One item at a time, set by the accept/execute sequence and the
// single RAM read port; a stalled output holds the block until it is free.
// Reset: depth 0, surface 640 x 480, no result pending; the stack RAM is not
// cleared, its entries are written by push before they are read.
module clip_rectangle_stack_unit
	import crs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// input items
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [15:0] pos_x, [31:16] pos_y, [47:32] size_w, [63:48] size_h
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [3:0] action
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	// result items
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [17:0] out_x, [35:18] out_y, [53:36] out_w, [71:54] out_h,
	// [72] pass, [77:73] stack_level, [79:78] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// configuration writes: index 0 surface_width, 1 surface_height
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CRD_W-1:0]       cfg_data
);

	crs_cmd_t  cmd;
	crs_stat_t stat;

	// surface registers take a write in any cycle
	assign cfg_ready = 1'b1;

	// controller: accept, execute, optional RAM read, hand over to output
	crs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// datapath: geometry, depth counter, active rectangle, stack RAM
	crs_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

// ===== rtl/crs_checker.sv =====
// Port-level checks for clip_rectangle_stack_unit, attached by bind.
// Depends on crs_pkg.
module crs_checker
	import crs_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item at a time: no transfer right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// depth never exceeds the stack size
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (STACK_DEPTH > 31) || (m_tdata[77:73] <= 5'(STACK_DEPTH)))
		else $error("stack level beyond depth");

	// configuration is never back-pressured
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port stalled");

endmodule

bind clip_rectangle_stack_unit crs_checker u_crs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.cfg_ready(cfg_ready)
);
